/* hw/rtl/assert_macros.svh */
// assertion macros used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* hw/rtl/fpba_pkg.sv */
// shared types and constants of the fit policy block allocator
package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_BITS_DEF  = 16;

  localparam int IDX_FIELD_W  = 4;
  localparam int SIZE_FIELD_W = 16;
  localparam int CNT_FIELD_W  = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST,
    FIT_BEST,
    FIT_WORST,
    FIT_NEXT
  } fit_policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } fpba_state_t;

  // control from the sequencer to the picker
  typedef struct packed {
    logic clear;
    logic sample;
    logic take_min;
    logic take_max;
  } pick_ctl_t;

endpackage

/* hw/rtl/fpba_cap_mem.sv */
// capacity memory with per-entry valid bits; unwritten entries read as zero
module fpba_cap_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_q <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

/* hw/rtl/fpba_picker.sv */
// keeps the best candidate block seen so far during a scan
module fpba_picker import fpba_pkg::*; #(
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pick_ctl_t            ctl,
  input  logic [IDX_W-1:0]     rd_idx,
  input  logic [SIZE_BITS-1:0] rd_cap,
  input  logic [SIZE_BITS-1:0] size,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx,
  output logic [SIZE_BITS-1:0] pick_cap
);

  logic fits;
  logic take;

  assign fits = rd_cap >= size;
  // first and next fit keep the first hit in scan order
  assign take = ctl.sample && fits &&
                (!found || (ctl.take_min && rd_cap < pick_cap) ||
                 (ctl.take_max && rd_cap > pick_cap));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx <= rd_idx;
      pick_cap <= rd_cap;
    end
  end

endmodule

/* hw/rtl/fit_policy_block_allocator_core.sv */
// fit policy block allocator: sequencer, config registers and result register
// a load goes from idle straight to commit; an allocate scans count blocks, then drains
// and commits, count being blocks_in_use saturated at NUM_BLOCKS, or commits directly when count is zero
// one item in flight; the next is accepted while the result word waits at the output
// reset clears the capacity table (valid bits) and next fit pointer, and sets the config to first fit, sixteen blocks
module fit_policy_block_allocator_core import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // block_index, req_size, zero pad
  input  logic [0:0]           s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // chosen_block, remaining, zero pad
  output logic [0:0]           m_tuser,   // granted
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [4:0]           cfg_data
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  fpba_state_t state, state_next;

  fit_policy_t              fit_policy;
  logic [CNT_FIELD_W-1:0]   blocks_in_use;
  logic [IDX_W-1:0]         nf_start;

  logic                     item_type;
  logic [IDX_FIELD_W-1:0]   item_idx;
  logic [SIZE_BITS-1:0]     item_size;

  logic [IDX_W-1:0]         scan_addr;
  logic [CNT_W-1:0]         scan_cnt;
  logic                     rd_pend;
  logic [IDX_W-1:0]         rd_idx;

  logic                     out_granted;
  logic [IDX_FIELD_W-1:0]   out_block;
  logic [SIZE_FIELD_W-1:0]  out_rem;

  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         start_eff;
  logic                     accept;
  logic                     scan_last;
  logic                     addr_last;
  logic                     commit_go;
  logic                     load_ok;
  logic                     res_granted;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [SIZE_BITS-1:0]     mem_wdata;
  logic                     rd_en;
  logic [SIZE_BITS-1:0]     rd_cap;
  pick_ctl_t                pick_ctl;
  logic                     pick_found;
  logic [IDX_W-1:0]         pick_idx;
  logic [SIZE_BITS-1:0]     pick_cap;

  // block count saturates at the table depth
  assign count = (32'(blocks_in_use) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                   : CNT_W'(blocks_in_use);
  assign start_eff = (fit_policy == FIT_NEXT && 32'(nf_start) < 32'(count))
                     ? nf_start : '0;

  assign accept    = s_tvalid && s_tready;
  assign scan_last = 32'(scan_cnt) == 32'(count) - 1;
  assign addr_last = 32'(scan_addr) == 32'(count) - 1;
  assign load_ok   = 32'(item_idx) < 32'(count);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser[0] == REQ_ALLOC && count != '0) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_COMMIT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready          = state == ST_IDLE;
    rd_en             = state == ST_SCAN;
    commit_go         = (state == ST_COMMIT) && (!m_tvalid || m_tready);
    pick_ctl.clear    = accept;
    pick_ctl.sample   = rd_pend;
    pick_ctl.take_min = fit_policy == FIT_BEST;
    pick_ctl.take_max = fit_policy == FIT_WORST;
    if (item_type == REQ_ALLOC) begin
      res_granted = pick_found;
      mem_waddr   = pick_idx;
      mem_wdata   = pick_cap - item_size;
    end else begin
      res_granted = load_ok;
      mem_waddr   = IDX_W'(item_idx);
      mem_wdata   = item_size;
    end
    mem_we = commit_go && res_granted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fit_policy    <= FIT_FIRST;
      blocks_in_use <= CNT_FIELD_W'(16);
      nf_start      <= '0;
      rd_pend       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FIT_POLICY:    fit_policy <= fit_policy_t'(cfg_data[1:0]);
          CFG_BLOCKS_IN_USE: blocks_in_use <= cfg_data;
          default: begin
          end
        endcase
      end
      if (commit_go && item_type == REQ_ALLOC && pick_found && fit_policy == FIT_NEXT) begin
        nf_start <= pick_idx;
      end
      if (commit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_type <= s_tuser[0];
      item_idx  <= s_tdata[3:0];
      item_size <= SIZE_BITS'(s_tdata[19:4]);
      scan_addr <= start_eff;
      scan_cnt  <= '0;
    end else if (state == ST_SCAN) begin
      scan_cnt  <= scan_cnt + CNT_W'(1);
      scan_addr <= addr_last ? '0 : scan_addr + IDX_W'(1);
    end
    rd_idx <= scan_addr;
    if (commit_go) begin
      out_granted <= res_granted;
      if (res_granted) begin
        out_block <= (item_type == REQ_ALLOC) ? IDX_FIELD_W'(pick_idx) : item_idx;
        out_rem   <= SIZE_FIELD_W'(mem_wdata);
      end else begin
        out_block <= '0;
        out_rem   <= '0;
      end
    end
  end

  assign m_tdata = {4'b0, out_rem, out_block};
  assign m_tuser = out_granted;

  fpba_cap_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .IDX_W (IDX_W)
  ) u_cap_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_cap)
  );

  fpba_picker #(
    .IDX_W     (IDX_W),
    .SIZE_BITS (SIZE_BITS)
  ) u_picker (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pick_ctl),
    .rd_idx   (rd_idx),
    .rd_cap   (rd_cap),
    .size     (item_size),
    .found    (pick_found),
    .pick_idx (pick_idx),
    .pick_cap (pick_cap)
  );

`include "assert_macros.svh"

  `ASSERT_PROP(a_alloc_scans, clk, rst, (accept && s_tuser[0] == REQ_ALLOC && count != '0) |=> state == ST_SCAN, "allocate did not start a scan")
  `ASSERT_NEVER(a_rd_wr_overlap, clk, rst, rd_en && mem_we, "capacity read overlaps write back")
  `ASSERT_PROP(a_scan_in_range, clk, rst, (state == ST_SCAN) |-> 32'(scan_addr) < 32'(count), "scan address beyond blocks in use")
  `ASSERT_PROP(a_pick_in_range, clk, rst, (state == ST_COMMIT && pick_found) |-> 32'(pick_idx) < 32'(count), "picked block beyond blocks in use")

endmodule

/* tb/sv/tb_fit_policy_block_allocator_core.sv */
// testbench for the fit policy block allocator: directed and random stream traffic checked by a predictor
`timescale 1ns / 100ps

module tb_fit_policy_block_allocator_core import fpba_pkg::*;;

  localparam int IDLE_LIMIT = 1000;

  typedef struct packed {
    logic        granted;
    logic [3:0]  blk;
    logic [15:0] rem;
  } grant_word_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;   // block_index, req_size, zero pad
  logic [0:0]           s_tuser;   // req_type
  logic                 m_tvalid;
  logic                 m_tready;
  logic [23:0]          m_tdata;   // chosen_block, remaining, zero pad
  logic [0:0]           m_tuser;   // granted
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [4:0]           cfg_data;

  // predictor state
  logic [15:0]  free_cap [NUM_BLOCKS_DEF];
  logic [3:0]   next_fit_ptr;
  fit_policy_t  cur_policy;
  logic [4:0]   cur_blocks;

  grant_word_t  pending_grants[$];
  int           errors;
  int           idle_cycles;
  bit           no_gaps;

  fit_policy_block_allocator_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int active_blocks();
    return (cur_blocks > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(cur_blocks);
  endfunction

  // applies one request to the predicted capacity table and returns the expected word
  function automatic grant_word_t predict_grant(logic kind, logic [3:0] idx,
                                                logic [15:0] size);
    grant_word_t r;
    int cnt;
    int pick;
    int j;
    int first;
    r = '0;
    cnt = active_blocks();
    pick = -1;
    if (kind == REQ_LOAD) begin
      if (idx < cnt) begin
        free_cap[idx] = size;
        r.granted = 1'b1;
        r.blk = idx;
        r.rem = size;
      end
      return r;
    end
    if (cur_policy == FIT_NEXT) begin
      // circular scan, restarting at block 0 when the pointer is past the active range
      first = (next_fit_ptr >= cnt) ? 0 : int'(next_fit_ptr);
      for (int k = 0; k < cnt; k++) begin
        j = (first + k) % cnt;
        if (pick < 0 && free_cap[j] >= size) pick = j;
      end
    end else begin
      for (j = 0; j < cnt; j++) begin
        if (free_cap[j] >= size) begin
          if (pick < 0) pick = j;
          else if (cur_policy == FIT_BEST && free_cap[j] < free_cap[pick]) pick = j;
          else if (cur_policy == FIT_WORST && free_cap[j] > free_cap[pick]) pick = j;
        end
      end
    end
    if (pick >= 0) begin
      free_cap[pick] = free_cap[pick] - size;
      if (cur_policy == FIT_NEXT) next_fit_ptr = pick[3:0];
      r.granted = 1'b1;
      r.blk = pick[3:0];
      r.rem = free_cap[pick];
    end
    return r;
  endfunction

  task automatic send_request(logic kind, logic [3:0] idx, logic [15:0] size);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, size, idx};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_grants.push_back(predict_grant(kind, idx, size));
  endtask

  // stop sending and let every outstanding word come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIT_POLICY) cur_policy = fit_policy_t'(value[1:0]);
    else if (idx == CFG_BLOCKS_IN_USE) cur_blocks = value;
  endtask

  task automatic set_policy(fit_policy_t p);
    write_reg(CFG_FIT_POLICY, {3'b000, p});
  endtask

  // reset values: all capacities zero, first fit, sixteen blocks
  task automatic test_after_reset();
    send_request(REQ_ALLOC, 4'd0, 16'd0);       // zero size fits an empty block
    send_request(REQ_ALLOC, 4'd9, 16'hFFFF);    // nothing fits
    send_request(REQ_LOAD, 4'd15, 16'hFFFF);
    send_request(REQ_LOAD, 4'd0, 16'd0);
  endtask

  task automatic test_fit_policies();
    fit_policy_t p;
    send_request(REQ_LOAD, 4'd1, 16'd50);
    send_request(REQ_LOAD, 4'd2, 16'd20);
    send_request(REQ_LOAD, 4'd3, 16'd50);
    send_request(REQ_LOAD, 4'd4, 16'd20);
    for (int i = 0; i < 4; i++) begin
      p = fit_policy_t'(i);
      set_policy(p);
      send_request(REQ_ALLOC, 4'd0, 16'd10);
    end
  endtask

  task automatic test_block_counts();
    write_reg(CFG_BLOCKS_IN_USE, 5'd1);
    send_request(REQ_LOAD, 4'd1, 16'd300);      // outside the active range
    send_request(REQ_ALLOC, 4'd0, 16'hFFFF);
    write_reg(CFG_BLOCKS_IN_USE, 5'd0);
    send_request(REQ_LOAD, 4'd0, 16'd5);
    send_request(REQ_ALLOC, 4'd0, 16'd0);
    write_reg(CFG_BLOCKS_IN_USE, 5'd31);        // saturates at the block count
    send_request(REQ_LOAD, 4'd15, 16'd7);
    send_request(REQ_ALLOC, 4'd3, 16'd7);
  endtask

  task automatic test_next_fit_wrap();
    write_reg(CFG_BLOCKS_IN_USE, 5'd16);
    send_request(REQ_LOAD, 4'd12, 16'd900);
    send_request(REQ_ALLOC, 4'd0, 16'd800);     // moves the pointer to block 12
    write_reg(CFG_BLOCKS_IN_USE, 5'd2);
    send_request(REQ_ALLOC, 4'd0, 16'd0);       // pointer past range, scan from block 0
  endtask

  function automatic logic [15:0] load_size();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 65535));
      1: begin
        // few distinct values so best and worst fit see ties
        case ($urandom_range(0, 3))
          0: return 16'd0;
          1: return 16'd1;
          2: return 16'd1000;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [15:0] alloc_size();
    int b;
    int cnt;
    cnt = active_blocks();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      3: return 16'($urandom_range(0, 255));
      default: begin
        // sized against a live block so most requests fit
        b = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        return 16'($urandom_range(0, free_cap[b]));
      end
    endcase
  endfunction

  task automatic test_random_traffic();
    fit_policy_t p;
    logic [4:0]  nblk;
    int          cnt;
    int          r;
    for (int phase = 0; phase < 16; phase++) begin
      p = (phase < 4) ? fit_policy_t'(phase) : fit_policy_t'($urandom_range(0, 3));
      case (phase)
        0: nblk = 5'd16;
        1: nblk = 5'd1;
        2: nblk = 5'd0;
        3: nblk = 5'd31;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) nblk = 5'($urandom_range(17, 31));
          else if (r == 1) nblk = 5'd0;
          else nblk = 5'($urandom_range(1, 16));
        end
      endcase
      set_policy(p);
      write_reg(CFG_BLOCKS_IN_USE, nblk);
      no_gaps = ($urandom_range(0, 3) == 0);
      cnt = active_blocks();
      for (int i = 0; i < 60; i++) begin
        r = $urandom_range(0, 99);
        if (r < 22 && cnt > 0)
          send_request(REQ_LOAD, 4'($urandom_range(0, cnt - 1)), load_size());
        else if (r < 28)
          send_request(REQ_LOAD, 4'($urandom_range(0, 15)), load_size());
        else
          send_request(REQ_ALLOC, 4'($urandom_range(0, 15)), alloc_size());
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    no_gaps = 1'b0;
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) free_cap[i] = '0;
    next_fit_ptr = '0;
    cur_policy = FIT_FIRST;
    cur_blocks = 5'd16;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_after_reset();
    test_fit_policies();
    test_block_counts();
    test_next_fit_wrap();
    test_random_traffic();
    drain();
    repeat (25) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fit_policy_block_allocator_core OK");
    end else begin
      $display("tb_fit_policy_block_allocator_core NOT OK");
    end
    $finish;
  end

  // result side: random stalls, compares each word with the oldest prediction
  initial begin : result_sink
    int stall;
    grant_word_t want;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      if (pending_grants.size() == 0) begin
        $error("unexpected result word: granted %0d chosen_block %0d remaining %0d",
               m_tuser[0], m_tdata[3:0], m_tdata[19:4]);
        errors++;
      end else begin
        want = pending_grants.pop_front();
        if (m_tuser[0] !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, m_tuser[0]);
          errors++;
        end
        if (m_tdata[3:0] !== want.blk) begin
          $error("chosen_block: expected %0d, got %0d", want.blk, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[19:4] !== want.rem) begin
          $error("remaining: expected %0d, got %0d", want.rem, m_tdata[19:4]);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_fit_policy_block_allocator_core NOT OK");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_cap_mem.sv
hw/rtl/fpba_picker.sv
hw/rtl/fit_policy_block_allocator_core.sv
tb/sv/tb_fit_policy_block_allocator_core.sv
